@@ src/apf_pkg.sv @@
`default_nettype none

package apf_pkg;

  // Field widths fixed by the item format.
  localparam int CH_FIELD_W  = 3;
  localparam int SEV_W       = 3;

  // Window registers.
  localparam int NUM_WIN_REGS = 8;
  localparam int WREG_IDX_W   = 3;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 8;

  typedef logic [CFG_DATA_W-1:0] win_reg_t;
  typedef logic [SEV_W-1:0]      sev_t;

  localparam win_reg_t WIN_RESET [NUM_WIN_REGS] = '{
    8'd90, 8'd90, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12
  };

  // Severity codes.
  localparam sev_t SEV_NONE    = 3'd0;
  localparam sev_t SEV_UNKNOWN = 3'd4;
  // Larger than every legal code, so it never wins a minimum.
  localparam sev_t SEV_NEUTRAL = 3'd7;

  function automatic sev_t sev_min(input sev_t a, input sev_t b);
    sev_min = (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

@@ src/apf_if.sv @@
`default_nettype none

interface apf_in_if;
  import apf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel;
  logic [SEV_W-1:0]      severity;
  logic                  read_alarm;

  modport source (output valid, output channel, output severity, output read_alarm,
                  input ready);
  modport sink   (input valid, input channel, input severity, input read_alarm,
                  output ready);
endinterface

interface apf_out_if;
  import apf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel_out;
  logic [SEV_W-1:0]      comm_severity;
  logic [SEV_W-1:0]      value_severity;

  modport source (output valid, output channel_out, output comm_severity,
                  output value_severity, input ready);
  modport sink   (input valid, input channel_out, input comm_severity,
                  input value_severity, output ready);
endinterface

interface apf_cfg_if;
  import apf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/apf_cell.sv @@
`default_nettype none

// One history position for every channel. On a shift the selected
// channel's entry takes the value handed over by the neighboring cell.
module apf_cell #(
  parameter int CHANNELS = 8,
  parameter int CH_W     = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic [CH_W-1:0]     ch_i,
  input  apf_pkg::sev_t       data_i,
  output apf_pkg::sev_t       data_o
);
  import apf_pkg::*;

  sev_t store_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        store_q[c] <= SEV_NONE;
      end
    end else if (shift_i) begin
      store_q[ch_i] <= data_i;
    end
  end

  assign data_o = store_q[ch_i];

endmodule

`default_nettype wire

@@ src/apf_min_tree.sv @@
`default_nettype none

// Binary minimum tree in heap order. Leaves are loaded on load_i, and
// every third level up from the leaves is registered.
module apf_min_tree #(
  parameter int LEAVES = 128
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [LEAVES-1:0][apf_pkg::SEV_W-1:0] leaf_i,
  output apf_pkg::sev_t                       root_o
);
  import apf_pkg::*;

  localparam int LOG = $clog2(LEAVES);

  sev_t node [1:2*LEAVES-1];

  for (genvar k = LEAVES; k < 2*LEAVES; k++) begin : g_leaf
    sev_t leaf_q;

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        leaf_q <= leaf_i[k-LEAVES];
      end
    end

    assign node[k] = leaf_q;
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    localparam int LV = $clog2(k+1) - 1;
    if (((LOG - LV) % 3) == 0) begin : g_reg
      sev_t node_q;

      always_ff @(posedge clk_i) begin
        node_q <= sev_min(node[2*k], node[2*k+1]);
      end

      assign node[k] = node_q;
    end else begin : g_comb
      assign node[k] = sev_min(node[2*k], node[2*k+1]);
    end
  end

  assign root_o = node[1];

endmodule

`default_nettype wire

@@ src/alarm_persistence_filter_top.sv @@
`default_nettype none

// Channel | Dir | Handshake     | Payload
// cfg_i   | in  | valid / ready | index, data (window registers 0..7)
// in_i    | in  | valid / ready | channel, severity, read_alarm
// out_o   | out | valid / ready | channel_out, comm_severity, value_severity
//
// An item passes from the input register through the history shift and the
// registered levels of the minimum tree to the output register; the tree has
// LEAVES leaves, where LEAVES is MAX_WINDOW rounded up to a power of two.
// The next item is accepted in the cycle its predecessor's result is registered.
// Reset clears the whole history at once; the block is ready right after reset.
// A stalled output holds its result and holds off the next item's completion.
module alarm_persistence_filter_top #(
  parameter int CHANNELS   = 8,
  parameter int MAX_WINDOW = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  apf_cfg_if.sink  cfg_i,
  apf_in_if.sink   in_i,
  apf_out_if.source out_o
);
  import apf_pkg::*;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
  localparam int LEAVES   = (MAX_WINDOW < 2) ? 2 : (2 ** $clog2(MAX_WINDOW));
  localparam int LOG      = $clog2(LEAVES);
  localparam int TREE_LAT = 1 + LOG / 3;
  localparam int CNT_W    = $clog2(TREE_LAT + 1);

  // Window registers.
  win_reg_t win_regs_q [NUM_WIN_REGS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_WIN_REGS; r++) begin
        win_regs_q[r] <= WIN_RESET[r];
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_WIN_REGS))) begin
      win_regs_q[cfg_i.index[WREG_IDX_W-1:0]] <= cfg_i.data;
    end
  end

  // Input decode.
  logic             in_acc;
  logic             finish;
  sev_t             sev_c;
  win_reg_t         win_raw;
  logic [WIN_W-1:0] win_eff;

  assign in_acc = in_i.valid && in_i.ready;
  assign sev_c  = (in_i.severity > SEV_UNKNOWN) ? SEV_UNKNOWN : in_i.severity;
  assign win_raw = win_regs_q[in_i.channel];

  always_comb begin
    if (win_raw == '0) begin
      win_eff = WIN_W'(1);
    end else if (int'(win_raw) > MAX_WINDOW) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_W'(win_raw);
    end
  end

  logic [CH_FIELD_W-1:0] ch_q;
  sev_t                  entry_q;
  sev_t                  val_q;
  logic [WIN_W-1:0]      win_q;
  logic                  ch_ok_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q    <= in_i.channel;
      entry_q <= in_i.read_alarm ? sev_c : SEV_NONE;
      val_q   <= in_i.read_alarm ? SEV_NONE : sev_c;
      win_q   <= win_eff;
      ch_ok_q <= (int'(in_i.channel) < CHANNELS);
    end
  end

  // Sequencing.
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             shift;
  logic             tree_done;

  assign tree_done = busy_q && (cnt_q == CNT_W'(TREE_LAT));
  assign finish    = tree_done && (!out_valid_q || out_o.ready);
  assign shift     = busy_q && (cnt_q == '0);
  assign in_i.ready = !busy_q || finish;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (finish) begin
      busy_d = 1'b0;
    end
    if (in_acc) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q && !tree_done) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // History cells: cell i holds position i of every channel's history.
  logic [CH_W-1:0] ch_idx;
  sev_t            cell_out [MAX_WINDOW];

  assign ch_idx = CH_W'(ch_q);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    sev_t cell_in;
    logic cell_shift;

    if (i == 0) begin : g_head
      assign cell_in = entry_q;
    end else begin : g_body
      assign cell_in = cell_out[i-1];
    end

    assign cell_shift = shift && ch_ok_q && (i < int'(win_q));

    apf_cell #(
      .CHANNELS (CHANNELS),
      .CH_W     (CH_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (cell_shift),
      .ch_i    (ch_idx),
      .data_i  (cell_in),
      .data_o  (cell_out[i])
    );
  end

  // Only the window-1 entries kept behind the new one take part in the minimum.
  logic [LEAVES-1:0][SEV_W-1:0] leaf;
  sev_t                         root;

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < MAX_WINDOW) begin : g_pos
      assign leaf[j] = (ch_ok_q && ((j + 1) < int'(win_q))) ? cell_out[j] : SEV_NEUTRAL;
    end else begin : g_pad
      assign leaf[j] = SEV_NEUTRAL;
    end
  end

  apf_min_tree #(
    .LEAVES (LEAVES)
  ) u_tree (
    .clk_i  (clk_i),
    .load_i (shift),
    .leaf_i (leaf),
    .root_o (root)
  );

  // Output register.
  logic [CH_FIELD_W-1:0] out_ch_q;
  sev_t                  out_comm_q;
  sev_t                  out_val_q;

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_ch_q   <= ch_q;
      out_comm_q <= sev_min(entry_q, root);
      out_val_q  <= val_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.channel_out    = out_ch_q;
  assign out_o.comm_severity  = out_comm_q;
  assign out_o.value_severity = out_val_q;

endmodule

`default_nettype wire

@@ src/apf_checker.sv @@
`default_nettype none

module apf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [apf_pkg::CH_FIELD_W-1:0] out_channel,
  input logic [apf_pkg::SEV_W-1:0]      out_comm,
  input logic [apf_pkg::SEV_W-1:0]      out_value
);
  import apf_pkg::*;

  // A result waiting at the output stays there.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_channel) && $stable(out_comm)
                                && $stable(out_value))
    else $error("output item changed while stalled");

  // A non-read alarm enters zero into the history, so one of the two is zero.
  a_sev_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_comm == SEV_NONE) || (out_value == SEV_NONE))
    else $error("both severities nonzero");

  a_sev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_comm <= SEV_UNKNOWN) && (out_value <= SEV_UNKNOWN))
    else $error("severity code out of range");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

endmodule

bind alarm_persistence_filter_top apf_checker u_apf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_channel (out_o.channel_out),
  .out_comm    (out_o.comm_severity),
  .out_value   (out_o.value_severity)
);

`default_nettype wire
